FILE: hdl/phq_pkg.sv
// phq_pkg: shared types and constants for the per-host byte quota meter
// used by the front end, the command queue, the back end and the top level
// no dependencies
package phq_pkg;

  // fixed field widths of the item and register interface
  localparam int IDX_IN_W    = 4;
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 32;
  localparam int LEN_W       = 16;
  localparam int WCOUNT_W    = 5;
  localparam int MAX_SLOTS   = 16;
  localparam int QUEUE_DEPTH = 2;

  // packet classification constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // input function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_PACKET = 1'b1;

  // configuration register indexes
  localparam logic REG_BYTE_QUOTA  = 1'b0;
  localparam logic REG_WATCH_COUNT = 1'b1;

  // classified command kinds
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_PKT,
    CMD_PASS
  } cmd_kind_t;

  // one classified item as it travels from front end to back end
  typedef struct packed {
    cmd_kind_t              kind;
    logic [IDX_IN_W-1:0]    slot;
    logic [ADDR_W-1:0]      addr_a;   // load address or packet source
    logic [ADDR_W-1:0]      addr_b;   // packet destination
    logic [LEN_W-1:0]       len;
  } cmd_t;

endpackage

FILE: hdl/phq_front.sv
// phq_front: accepts items and classifies them into load, counted packet or pass
// depends on phq_pkg
module phq_front import phq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [IDX_IN_W-1:0] in_entry_index,
  input  logic [ADDR_W-1:0]   in_entry_address,
  input  logic [15:0]         in_ether_type,
  input  logic [7:0]          in_ip_protocol,
  input  logic [ADDR_W-1:0]   in_source_ip,
  input  logic [ADDR_W-1:0]   in_dest_ip,
  input  logic [LEN_W-1:0]    in_captured_length,
  input  logic                q_full,
  output logic                q_push,
  output cmd_t                q_cmd
);

  logic vld_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;
  logic accept;

  // hand the held item to the queue when there is room
  assign q_push = vld_r && !q_full;
  assign q_cmd  = cmd_r;
  assign busy   = vld_r && q_full;
  assign accept = start && !busy;

  // classify the incoming item
  always_comb begin
    cmd_nxt.slot   = in_entry_index;
    cmd_nxt.addr_b = in_dest_ip;
    cmd_nxt.len    = in_captured_length;
    if (in_func == FUNC_LOAD) begin
      cmd_nxt.kind   = CMD_LOAD;
      cmd_nxt.addr_a = in_entry_address;
    end else begin
      cmd_nxt.addr_a = in_source_ip;
      if (in_ether_type == ETHERTYPE_IPV4 &&
          (in_ip_protocol == PROTO_TCP || in_ip_protocol == PROTO_UDP)) begin
        cmd_nxt.kind = CMD_PKT;
      end else begin
        cmd_nxt.kind = CMD_PASS;
      end
    end
  end

  // holding register for the classified item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (accept) begin
      vld_r <= 1'b1;
    end else if (q_push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

FILE: hdl/phq_queue.sv
// phq_queue: short in-order command queue between front end and back end
// depends on phq_pkg
module phq_queue import phq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_vld,
  output cmd_t head_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // no item may be offered to a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push to full command queue");

endmodule

FILE: hdl/phq_back.sv
// phq_back: watched table match stage and counter update stage
// depends on phq_pkg
module phq_back import phq_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [COUNT_W-1:0]  byte_quota,
  input  logic [WCOUNT_W-1:0] watch_count,
  input  logic                q_vld,
  input  cmd_t                q_cmd,
  output logic                q_pop,
  output logic                out_strobe,
  output logic                out_matched,
  output logic [IDX_IN_W-1:0] out_matched_slot,
  output logic [ADDR_W-1:0]   out_matched_ip,
  output logic [COUNT_W-1:0]  out_byte_total,
  output logic                out_limit_event
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // watched table, undefined until loaded
  logic [ADDR_W-1:0]  tab_r   [SLOTS];
  logic [COUNT_W-1:0] bytes_r [SLOTS];
  logic [SLOTS-1:0]   lim_r;

  // match stage registers
  logic               a_vld_r;
  cmd_kind_t          a_kind_r;
  logic               a_hit_r;
  logic [IDX_W-1:0]   a_slot_r;
  logic [ADDR_W-1:0]  a_ip_r;
  logic [LEN_W-1:0]   a_len_r;

  // output registers
  logic               strobe_r;
  logic               matched_r;
  logic [IDX_IN_W-1:0] mslot_r;
  logic [ADDR_W-1:0]  mip_r;
  logic [COUNT_W-1:0] total_r;
  logic               limit_r;

  logic [WCOUNT_W-1:0] n_eff;
  logic [SLOTS-1:0]    match;
  logic [IDX_W-1:0]    sel;
  logic                load_ok;
  logic                b_wr;
  logic                over;
  logic [COUNT_W-1:0]  cur;
  logic [COUNT_W:0]    sum;
  logic [COUNT_W-1:0]  bytes_nxt;

  assign q_pop   = q_vld;
  assign load_ok = ({1'b0, q_cmd.slot} < (IDX_IN_W + 1)'(SLOTS));

  // number of live table entries
  assign n_eff = (watch_count > WCOUNT_W'(SLOTS)) ? WCOUNT_W'(SLOTS) : watch_count;

  // compare every live entry against source and destination
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (WCOUNT_W'(i) < n_eff) &&
                 (tab_r[i] == q_cmd.addr_a || tab_r[i] == q_cmd.addr_b);
    end
  end

  // lowest matching entry wins
  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  // table write for load items
  always_ff @(posedge clk) begin
    if (q_vld && q_cmd.kind == CMD_LOAD && load_ok) begin
      tab_r[q_cmd.slot[IDX_W-1:0]] <= q_cmd.addr_a;
    end
  end

  // match stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (q_vld) begin
      a_kind_r <= q_cmd.kind;
      a_len_r  <= q_cmd.len;
      a_ip_r   <= tab_r[sel];
      unique case (q_cmd.kind)
        CMD_LOAD: begin
          a_hit_r  <= load_ok;
          a_slot_r <= q_cmd.slot[IDX_W-1:0];
        end
        CMD_PKT: begin
          a_hit_r  <= |match;
          a_slot_r <= sel;
        end
        default: begin
          a_hit_r  <= 1'b0;
          a_slot_r <= sel;
        end
      endcase
    end
  end

  // counter read-modify-write with quota check and saturation
  assign cur  = bytes_r[a_slot_r];
  assign over = lim_r[a_slot_r] || (byte_quota <= cur);
  assign sum  = {1'b0, cur} + (COUNT_W + 1)'(a_len_r);
  assign b_wr = a_vld_r && a_hit_r && (a_kind_r == CMD_LOAD || a_kind_r == CMD_PKT);

  always_comb begin
    if (a_kind_r == CMD_LOAD) begin
      bytes_nxt = '0;
    end else if (over) begin
      bytes_nxt = cur;
    end else if (sum[COUNT_W]) begin
      bytes_nxt = '1;
    end else begin
      bytes_nxt = sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        bytes_r[i] <= '0;
      end
      lim_r <= '0;
    end else if (b_wr) begin
      bytes_r[a_slot_r] <= bytes_nxt;
      lim_r[a_slot_r]   <= (a_kind_r == CMD_PKT) && over;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld_r && a_hit_r && a_kind_r == CMD_PKT) begin
      matched_r <= 1'b1;
      mslot_r   <= IDX_IN_W'(a_slot_r);
      mip_r     <= a_ip_r;
      total_r   <= bytes_nxt;
      limit_r   <= over;
    end else begin
      matched_r <= 1'b0;
      mslot_r   <= '0;
      mip_r     <= '0;
      total_r   <= '0;
      limit_r   <= 1'b0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_matched      = matched_r;
  assign out_matched_slot = mslot_r;
  assign out_matched_ip   = mip_r;
  assign out_byte_total   = total_r;
  assign out_limit_event  = limit_r;

  // every item leaving the match stage yields one result next cycle
  a_stage_result: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |=> out_strobe)
    else $error("match stage item produced no result");

  // a limit event only ever names a matched slot
  a_limit_matched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_limit_event) |-> out_matched)
    else $error("limit event without a match");

  // an unmatched result carries all zero fields
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_matched) |->
      (out_byte_total == '0 && out_matched_ip == '0 && out_matched_slot == '0))
    else $error("unmatched result with nonzero payload");

endmodule

FILE: hdl/per_host_byte_quota_meter.sv
// per_host_byte_quota_meter: the path from the accepting edge to the result edge runs through the
// front register, command queue, match stage and counter stage; one item per cycle sustained,
// limited by the counter read-modify-write in the back end
// results come on out_strobe for one cycle and cannot be held off by the receiver
// reset: counters and limited flags clear, byte_quota all ones, watch_count zero,
// watched table undefined until each slot is loaded
module per_host_byte_quota_meter import phq_pkg::*; #(
  parameter int WATCH_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [IDX_IN_W-1:0] in_entry_index,
  input  logic [ADDR_W-1:0]   in_entry_address,
  input  logic [15:0]         in_ether_type,
  input  logic [7:0]          in_ip_protocol,
  input  logic [ADDR_W-1:0]   in_source_ip,
  input  logic [ADDR_W-1:0]   in_dest_ip,
  input  logic [LEN_W-1:0]    in_captured_length,
  output logic                out_strobe,
  output logic                out_matched,
  output logic [IDX_IN_W-1:0] out_matched_slot,
  output logic [ADDR_W-1:0]   out_matched_ip,
  output logic [COUNT_W-1:0]  out_byte_total,
  output logic                out_limit_event,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [COUNT_W-1:0]  cfg_wdata
);

  // only sixteen slots are addressable by a load
  localparam int SLOTS = (WATCH_ENTRIES < MAX_SLOTS) ? WATCH_ENTRIES : MAX_SLOTS;

  logic [COUNT_W-1:0]  byte_quota_r;
  logic [WCOUNT_W-1:0] watch_count_r;
  logic                q_full;
  logic                q_push;
  cmd_t                q_in;
  logic                q_vld;
  cmd_t                q_head;
  logic                q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_quota_r  <= '1;
      watch_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYTE_QUOTA:  byte_quota_r  <= cfg_wdata;
        REG_WATCH_COUNT: watch_count_r <= cfg_wdata[WCOUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  // accept and classify
  phq_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_entry_index     (in_entry_index),
    .in_entry_address   (in_entry_address),
    .in_ether_type      (in_ether_type),
    .in_ip_protocol     (in_ip_protocol),
    .in_source_ip       (in_source_ip),
    .in_dest_ip         (in_dest_ip),
    .in_captured_length (in_captured_length),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (q_in)
  );

  // decoupling queue
  phq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .head_vld (q_vld),
    .head_cmd (q_head)
  );

  // table match and counter update
  phq_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_quota       (byte_quota_r),
    .watch_count      (watch_count_r),
    .q_vld            (q_vld),
    .q_cmd            (q_head),
    .q_pop            (q_pop),
    .out_strobe       (out_strobe),
    .out_matched      (out_matched),
    .out_matched_slot (out_matched_slot),
    .out_matched_ip   (out_matched_ip),
    .out_byte_total   (out_byte_total),
    .out_limit_event  (out_limit_event)
  );

endmodule
